// File: rtl/core/btpc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies; every other file imports this package.
`default_nettype none
package btpc_pkg;

  localparam int unsigned CalW   = 48;
  localparam int unsigned AdcW   = 20;
  localparam int unsigned TempW  = 15;
  localparam int unsigned PressW = 25;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW = 2'd1;
  localparam logic [1:0] REG_PRESS_MID = 2'd2;
  localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

  localparam logic signed [63:0] TEMP_MIN = -64'sd4000;
  localparam logic signed [63:0] TEMP_MAX = 64'sd8500;
  localparam logic [63:0] PRESS_MAX = 64'd33554431;

  // calibration words
  typedef struct packed {
    logic [15:0] t1, t2, t3;
    logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } btpc_cal_t;

  // sign-extend a 16-bit calibration word
  function automatic logic [63:0] sx16(input logic [15:0] w);
    sx16 = {{48{w[15]}}, w};
  endfunction

  // zero-extend a 16-bit calibration word
  function automatic logic [63:0] zx16(input logic [15:0] w);
    zx16 = {48'd0, w};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/btpc_if.sv
// Valid/ready channel interfaces for raw sensor words and result words.
// Depends on btpc_pkg for field widths.
`default_nettype none
interface btpc_in_if import btpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] t_hi_byte;
  logic [7:0] t_mid_byte;
  logic [7:0] t_lo_byte;
  logic [7:0] press_msb;
  logic [7:0] press_lsb;
  logic [7:0] press_xlsb;
  modport source (output valid, t_hi_byte, t_mid_byte, t_lo_byte,
                  press_msb, press_lsb, press_xlsb, input ready);
  modport sink (input valid, t_hi_byte, t_mid_byte, t_lo_byte,
                press_msb, press_lsb, press_xlsb, output ready);
endinterface

interface btpc_out_if import btpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TempW-1:0]  temperature_centi;
  logic [PressW-1:0]        pressure_q24_8;
  logic                     divide_fault;
  modport source (output valid, temperature_centi, pressure_q24_8, divide_fault,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, divide_fault,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/btpc_front.sv
// Front end: accepts raw sensor words, assembles the 20-bit readings and
// queues them (two entries) for the back end. Depends on btpc_pkg, btpc_if.
`default_nettype none
module btpc_front import btpc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  btpc_in_if.sink              in_ch,
  output logic                 q_valid,
  output logic [AdcW-1:0]      q_adc_t,
  output logic [AdcW-1:0]      q_adc_p,
  input  wire logic            q_pop
);

  logic [AdcW-1:0] adc_t_mem [2];
  logic [AdcW-1:0] adc_p_mem [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push;
  logic            pop;

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid & in_ch.ready;
  assign pop         = q_pop & q_valid;

  assign q_valid = (count_r != 2'd0);
  assign q_adc_t = adc_t_mem[rd_ptr_r];
  assign q_adc_p = adc_p_mem[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // assemble readings: msb, lsb, upper nibble of xlsb
  always_ff @(posedge clk) begin
    if (push) begin
      adc_t_mem[wr_ptr_r] <= {in_ch.t_hi_byte, in_ch.t_mid_byte, in_ch.t_lo_byte[7:4]};
      adc_p_mem[wr_ptr_r] <= {in_ch.press_msb, in_ch.press_lsb, in_ch.press_xlsb[7:4]};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/btpc_mul.sv
// 64x64 wrapping multiplier (low 64 bits) built on one 32x32 multiplier:
// three partial products taken in turn, then done is raised. Depends on btpc_pkg.
`default_nettype none
module btpc_mul import btpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] op_a,
  input  wire logic [63:0] op_b,
  output logic             done,
  output logic [63:0]      product
);

  logic [63:0] a_r, b_r;
  logic [63:0] prod_r;
  logic [63:0] lo_r;
  logic [31:0] cross_r;
  logic [2:0]  ph_r;
  logic        done_r;
  logic [31:0] ma, mb;

  // operand select per phase
  always_comb begin
    ma = (ph_r == 3'd3) ? a_r[63:32] : a_r[31:0];
    mb = (ph_r == 3'd2) ? b_r[63:32] : b_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        3'd0: if (start) ph_r <= 3'd1;
        3'd1, 3'd2, 3'd3: ph_r <= ph_r + 3'd1;
        3'd4: begin
          ph_r   <= 3'd0;
          done_r <= 1'b1;
        end
        default: ph_r <= 3'd0;
      endcase
    end
  end

  // datapath: partial products accumulated into low word
  always_ff @(posedge clk) begin
    if (ph_r == 3'd0 && start) begin
      a_r <= op_a;
      b_r <= op_b;
    end
    if (ph_r >= 3'd1 && ph_r <= 3'd3) prod_r <= 64'(ma) * 64'(mb);
    if (ph_r == 3'd2) lo_r <= prod_r;
    if (ph_r == 3'd3) cross_r <= prod_r[31:0];
    if (ph_r == 3'd4) cross_r <= cross_r + prod_r[31:0];
  end

  assign done    = done_r;
  assign product = lo_r + {cross_r, 32'd0};

endmodule
`default_nettype wire

// File: rtl/core/btpc_div.sv
// Signed 64-bit divider, truncating toward zero, restoring, one quotient
// bit per cycle (64 steps). Depends on btpc_pkg.
`default_nettype none
module btpc_div import btpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [63:0] q_r;
  logic [64:0] rem_r;
  logic [63:0] ub_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh = {rem_r[63:0], q_r[63]};
    fits   = (rem_sh >= {1'b0, ub_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // magnitudes in, one shift-subtract step a cycle
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= dividend[63] ? (64'd0 - dividend) : dividend;
      ub_r  <= divisor[63] ? (64'd0 - divisor) : divisor;
      neg_r <= dividend[63] ^ divisor[63];
      rem_r <= 65'd0;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, ub_r}) : rem_sh;
      q_r   <= {q_r[62:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (64'd0 - q_r) : q_r;

endmodule
`default_nettype wire

// File: rtl/core/btpc_back.sv
// Back end: sequences the compensation formulas over the shared multiplier
// and divider, then saturates into the output register.
// Depends on btpc_pkg, btpc_if, btpc_mul, btpc_div.
`default_nettype none
module btpc_back import btpc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire btpc_cal_t       cal,
  input  wire logic            q_valid,
  input  wire logic [AdcW-1:0] q_adc_t,
  input  wire logic [AdcW-1:0] q_adc_p,
  output logic                 q_pop,
  btpc_out_if.source           out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  // multiply steps of the formula
  typedef enum logic [3:0] {
    STP_TA   = 4'd0,
    STP_TDD  = 4'd1,
    STP_TB   = 4'd2,
    STP_VV   = 4'd3,
    STP_P6   = 4'd4,
    STP_P5   = 4'd5,
    STP_P3   = 4'd6,
    STP_P2   = 4'd7,
    STP_P1   = 4'd8,
    STP_NUM  = 4'd9,
    STP_XX   = 4'd10,
    STP_P9   = 4'd11,
    STP_P8   = 4'd12
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   mul_go_r, mul_go_nxt;
  logic   div_go_r, div_go_nxt;

  logic [AdcW-1:0] adc_t_r, adc_p_r;
  logic [63:0] a_r, tf_r, v1_r, vv_r, v2_r, tmp_r, num_r, p_r, s_r;
  logic        fault_r;

  logic [63:0] mul_a, mul_b, mul_p;
  logic        mul_done;
  logic [63:0] div_q;
  logic        div_done;

  logic                    out_valid_r;
  logic signed [TempW-1:0] out_temp_r;
  logic [PressW-1:0]       out_press_r;
  logic                    out_fault_r;

  logic [63:0] d_t, x13, tt, ts, pf, tf_sum;
  logic        out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  // multiplier operands per step
  always_comb begin
    d_t   = {48'd0, adc_t_r[AdcW-1:4]} - zx16(cal.t1);
    x13   = 64'($signed(p_r) >>> 13);
    mul_a = 64'd0;
    mul_b = 64'd0;
    case (step_r)
      STP_TA: begin
        mul_a = {47'd0, adc_t_r[AdcW-1:3]} - (zx16(cal.t1) << 1);
        mul_b = sx16(cal.t2);
      end
      STP_TDD: begin mul_a = d_t;  mul_b = d_t; end
      STP_TB:  begin mul_a = tmp_r; mul_b = sx16(cal.t3); end
      STP_VV:  begin mul_a = v1_r; mul_b = v1_r; end
      STP_P6:  begin mul_a = vv_r; mul_b = sx16(cal.p6); end
      STP_P5:  begin mul_a = v1_r; mul_b = sx16(cal.p5); end
      STP_P3:  begin mul_a = vv_r; mul_b = sx16(cal.p3); end
      STP_P2:  begin mul_a = v1_r; mul_b = sx16(cal.p2); end
      STP_P1:  begin mul_a = (64'd1 << 47) + tmp_r; mul_b = zx16(cal.p1); end
      STP_NUM: begin
        mul_a = (((64'd1048576 - {44'd0, adc_p_r}) << 31) - v2_r);
        mul_b = 64'd3125;
      end
      STP_XX:  begin mul_a = x13;  mul_b = x13; end
      STP_P9:  begin mul_a = tmp_r; mul_b = sx16(cal.p9); end
      STP_P8:  begin mul_a = p_r;  mul_b = sx16(cal.p8); end
      default: begin mul_a = 64'd0; mul_b = 64'd0; end
    endcase
  end

  btpc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go_r),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  btpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (num_r),
    .divisor  (v1_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    mul_go_nxt = 1'b0;
    div_go_nxt = 1'b0;
    q_pop      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          step_nxt   = STP_TA;
          mul_go_nxt = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (step_r == STP_P1 && 64'($signed(mul_p) >>> 33) == 64'd0) begin
            state_nxt = ST_FIN;
          end else if (step_r == STP_NUM) begin
            div_go_nxt = 1'b1;
            state_nxt  = ST_DIV;
          end else if (step_r == STP_P8) begin
            state_nxt = ST_FIN;
          end else begin
            step_nxt   = step_t'(step_r + 4'd1);
            mul_go_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          step_nxt   = STP_XX;
          mul_go_nxt = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= STP_TA;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      mul_go_r <= mul_go_nxt;
      div_go_r <= div_go_nxt;
    end
  end

  assign tf_sum = a_r + 64'($signed(mul_p) >>> 14);

  // post-processing of each product
  always_ff @(posedge clk) begin
    if (q_pop) begin
      adc_t_r <= q_adc_t;
      adc_p_r <= q_adc_p;
      fault_r <= 1'b0;
    end
    if (state_r == ST_DIV && div_done) p_r <= div_q;
    if (state_r == ST_MUL && mul_done) begin
      case (step_r)
        STP_TA:  a_r   <= 64'($signed(mul_p) >>> 11);
        STP_TDD: tmp_r <= 64'($signed(mul_p) >>> 12);
        STP_TB: begin
          tf_r <= tf_sum;
          v1_r <= tf_sum - 64'd128000;
        end
        STP_VV:  vv_r  <= mul_p;
        STP_P6:  v2_r  <= mul_p;
        STP_P5:  v2_r  <= v2_r + (mul_p << 17) + (sx16(cal.p4) << 35);
        STP_P3:  tmp_r <= 64'($signed(mul_p) >>> 8);
        STP_P2:  tmp_r <= tmp_r + (mul_p << 12);
        STP_P1: begin
          v1_r    <= 64'($signed(mul_p) >>> 33);
          fault_r <= (64'($signed(mul_p) >>> 33) == 64'd0);
        end
        STP_NUM: num_r <= mul_p;
        STP_XX:  tmp_r <= mul_p;
        STP_P9:  s_r   <= p_r + 64'($signed(mul_p) >>> 25);
        STP_P8:  s_r   <= s_r + 64'($signed(mul_p) >>> 19);
        default: tmp_r <= tmp_r;
      endcase
    end
  end

  // final scaling and saturation
  always_comb begin
    tt = (tf_r << 2) + tf_r + 64'd128;
    ts = 64'($signed(tt) >>> 8);
    pf = 64'($signed(s_r) >>> 8) + (sx16(cal.p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      if ($signed(ts) < TEMP_MIN) out_temp_r <= TempW'(TEMP_MIN);
      else if ($signed(ts) > TEMP_MAX) out_temp_r <= TempW'(TEMP_MAX);
      else out_temp_r <= ts[TempW-1:0];
      if (fault_r || pf[63]) out_press_r <= '0;
      else if (pf > PRESS_MAX) out_press_r <= PRESS_MAX[PressW-1:0];
      else out_press_r <= pf[PressW-1:0];
      out_fault_r <= fault_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.pressure_q24_8    = out_press_r;
  assign out_ch.divide_fault      = out_fault_r;

endmodule
`default_nettype wire

// File: rtl/core/baro_temp_pressure_compensation_top.sv
// Top level of the barometric compensation block: calibration registers,
// front end with queue, and compute back end. Depends on all rtl/core files.
//
// Each input word carries the six raw result bytes of one sensor conversion;
// each result word gives temperature in signed hundredths of a degree and
// pressure in 1/256 Pa, both saturated, plus a fault flag set when the
// pressure divisor is zero (pressure then reads 0). The front end takes a
// word whenever its two-entry queue has room, also while a result waits at
// the output. The back end runs one word at a time through a shared 64-bit
// multiplier (thirteen products) and a bit-serial 64-bit divider; a zero
// divisor skips the divider and the products after it. The next word
// leaves the queue in the cycle the result is offered, so the back end
// takes no new word before the last result is offered. The user must write
// calibration registers through the cfg port only while the block is idle;
// the block itself does not enforce this.
`default_nettype none
module baro_temp_pressure_compensation_top import btpc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  btpc_in_if.sink              in_ch,
  btpc_out_if.source           out_ch,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [CalW-1:0] cfg_wdata
);

  logic [CalW-1:0] temp_cal_r, press_low_r, press_mid_r, press_high_r;
  btpc_cal_t       cal;
  logic            q_valid;
  logic [AdcW-1:0] q_adc_t, q_adc_p;
  logic            q_pop;

  // calibration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r   <= '0;
      press_low_r  <= '0;
      press_mid_r  <= '0;
      press_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CAL:   temp_cal_r   <= cfg_wdata;
        REG_PRESS_LOW:  press_low_r  <= cfg_wdata;
        REG_PRESS_MID:  press_mid_r  <= cfg_wdata;
        REG_PRESS_HIGH: press_high_r <= cfg_wdata;
        default:        temp_cal_r   <= temp_cal_r;
      endcase
    end
  end

  // unpack words, lowest word first
  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_low_r[15:0];
    cal.p2 = press_low_r[31:16];
    cal.p3 = press_low_r[47:32];
    cal.p4 = press_mid_r[15:0];
    cal.p5 = press_mid_r[31:16];
    cal.p6 = press_mid_r[47:32];
    cal.p7 = press_high_r[15:0];
    cal.p8 = press_high_r[31:16];
    cal.p9 = press_high_r[47:32];
  end

  btpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_adc_t (q_adc_t),
    .q_adc_p (q_adc_p),
    .q_pop   (q_pop)
  );

  btpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .q_valid (q_valid),
    .q_adc_t (q_adc_t),
    .q_adc_p (q_adc_p),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
